### rtl/integer_to_decimal_ascii_defines.svh
// Assertion macros shared by the checker of the decimal ASCII converter.
// Plain text only; the including file supplies clock and reset names.
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define I2DA_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("i2da check failed");

// Next-cycle implication under an active-low reset.
`define I2DA_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("i2da check failed");

`endif

### rtl/i2da_pkg.sv
// Shared types and constants of the integer to decimal ASCII converter.
// No dependencies; the controller, datapath, top level, checker and testbench refer to this package.
`default_nettype none

package i2da_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int WSEL_W        = 7;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [1:0] WIDTH_BYTE = 2'd0;

    // Decimal digits needed for 2**w - 1 (may overshoot by one, never short).
    function automatic int digit_count(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } i2da_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic top_zero;
        logic rem_one;
        logic neg;
        logic slot_free;
    } i2da_status_t;

endpackage

`default_nettype wire

### rtl/i2da_if.sv
// Valid/ready channel interfaces of the decimal ASCII converter.
// Depends on nothing; the input channel carries the integer, the output one a character.
`default_nettype none

interface i2da_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_value;
    logic [1:0]  width_code;
    logic        is_signed;

    modport source (output valid, raw_value, width_code, is_signed, input ready);
    modport sink   (input valid, raw_value, width_code, is_signed, output ready);
endinterface

interface i2da_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink   (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

### rtl/i2da_ctrl.sv
// Controller state machine of the decimal ASCII converter.
// Depends on i2da_pkg for the command and status structs.
`default_nettype none

module i2da_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  i2da_pkg::i2da_status_t status,
    output i2da_pkg::i2da_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.cnt_last)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (status.top_zero && !status.rem_one)
                    cmd.skip = 1'b1;
                else if (status.neg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.rem_one)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/i2da_datapath.sv
// Datapath of the decimal ASCII converter: shift-and-add-3 BCD conversion,
// leading zero skip and the output character register. Depends on i2da_pkg.
`default_nettype none

module i2da_datapath #(
    parameter int MAX_WIDTH = i2da_pkg::MAX_WIDTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire  [63:0]            raw_value,
    input  wire  [1:0]             width_code,
    input  wire                    is_signed,
    input  i2da_pkg::i2da_cmd_t    cmd,
    output i2da_pkg::i2da_status_t status,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [7:0]             out_char,
    output logic                   last_char
);

    localparam int DIGITS = i2da_pkg::digit_count(MAX_WIDTH);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(DIGITS + 1);
    localparam int WSEL_W = i2da_pkg::WSEL_W;

    logic [MAX_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 last_reg, last_next;

    logic [WSEL_W-1:0]    wsel;
    logic [CW-1:0]        w_eff;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] mag;
    logic [MAX_WIDTH-1:0] mag_abs;
    logic [MAX_WIDTH-1:0] aligned;
    logic                 sign_bit;
    logic                 neg_now;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_digit;
    logic                 slot_free;

    // Operand width, mask and magnitude of the incoming item
    always_comb
    begin
        wsel     = WSEL_W'(8) << width_code;
        w_eff    = (wsel > WSEL_W'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(wsel);
        mask     = ~({MAX_WIDTH{1'b1}} << w_eff);
        mag      = raw_value[MAX_WIDTH-1:0] & mask;
        sign_bit = |(mag & (mask ^ (mask >> 1)));
        neg_now  = (width_code != i2da_pkg::WIDTH_BYTE) && is_signed && sign_bit;
        mag_abs  = neg_now ? ((~mag + MAX_WIDTH'(1)) & mask) : mag;
        // left-align so that exactly w_eff shifts consume the value
        aligned  = mag_abs << (CW'(MAX_WIDTH) - w_eff);
    end

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (cmd.load)
        begin
            bin_next = aligned;
            bcd_next = '0;
            cnt_next = w_eff;
            rem_next = RW'(DIGITS);
            neg_next = neg_now;
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[MAX_WIDTH-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg - CW'(1);
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next = bcd_reg << 4;
            rem_next = rem_reg - RW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = i2da_pkg::CHAR_MINUS;
            last_next      = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = i2da_pkg::CHAR_ZERO + {4'b0000, top_digit};
            last_next      = (rem_reg == RW'(1));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign status.cnt_last  = (cnt_reg == CW'(1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.rem_one   = (rem_reg == RW'(1));
    assign status.neg       = neg_reg;
    assign status.slot_free = slot_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

### rtl/integer_to_decimal_ascii.sv
// Integer to decimal ASCII converter, top level.
// Depends on i2da_pkg, i2da_if, i2da_ctrl and i2da_datapath.
//
// Usage: the input channel takes one integer item (raw_value, width_code,
// is_signed); the output channel returns its decimal text one character per
// item, most significant digit first, '-' first for a negative signed value,
// with last_char set on the final digit. Width code 0 is always unsigned.
// Flow: one item is converted at a time. After acceptance the value is shifted
// through shift-and-add-3 once per operand bit (w = 8, 16, 32 or 64, capped at
// MAX_WIDTH); leading zeros are then dropped and the remaining digits emitted,
// the sign first when negative. Dropped and emitted digits together number
// DIGITS (DIGITS = 20 for MAX_WIDTH 64). A single shared BCD shift register
// serves every item, so the next item is accepted only after the final digit
// has entered the output register.
// Stall: while the receiver holds ready low, the output register keeps its
// character and the emission pauses; the next item is accepted while the
// final character still waits. Reset clears the controller and output valid.
`default_nettype none

module integer_to_decimal_ascii #(
    parameter int MAX_WIDTH = i2da_pkg::MAX_WIDTH_DEF
) (
    input wire         clk,
    input wire         rst_n,
    i2da_in_if.sink    in_ch,
    i2da_out_if.source out_ch
);

    i2da_pkg::i2da_cmd_t    cmd;
    i2da_pkg::i2da_status_t status;

    i2da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    i2da_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_value  (in_ch.raw_value),
        .width_code (in_ch.width_code),
        .is_signed  (in_ch.is_signed),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_char   (out_ch.out_char),
        .last_char  (out_ch.last_char)
    );

endmodule

`default_nettype wire

### rtl/i2da_checker.sv
// Port-level checker of the decimal ASCII converter and its bind statement.
// Depends on i2da_pkg and the assertion macros header.
`default_nettype none
`include "integer_to_decimal_ascii_defines.svh"

module i2da_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] out_char,
    input wire       last_char
);

    `I2DA_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `I2DA_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_valid && !out_ready, $stable(out_char) && $stable(last_char))
    `I2DA_ASSERT_NOW(a_char_legal, clk, rst_n, out_valid, (out_char == i2da_pkg::CHAR_MINUS) || ((out_char >= i2da_pkg::CHAR_ZERO) && (out_char <= (i2da_pkg::CHAR_ZERO + 8'd9))))
    `I2DA_ASSERT_NOW(a_sign_not_last, clk, rst_n, out_valid && (out_char == i2da_pkg::CHAR_MINUS), !last_char)

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .last_char (out_ch.last_char)
);

`default_nettype wire

### bench/tb.sv
// Testbench of integer_to_decimal_ascii: random and corner integers in, decimal text checked.
// Depends on i2da_pkg, the i2da_in_if/i2da_out_if channels and the converter top level.
`default_nettype none

module tb;

    localparam logic [1:0] WIDTH_HALF  = 2'd1;
    localparam logic [1:0] WIDTH_WORD  = 2'd2;
    localparam logic [1:0] WIDTH_DWORD = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         TAIL_CYCLES = 100;
    localparam int         RANDOM_ITEMS = 357;

    typedef struct {
        logic [63:0] raw_value;
        logic [1:0]  width_code;
        logic        is_signed;
        logic        drain_first;
    } int_item_t;

    typedef struct {
        logic [7:0] out_char;
        logic       last_char;
    } text_char_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_STALLS, RX_SPARSE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    i2da_in_if  in_ch();
    i2da_out_if out_ch();

    integer_to_decimal_ascii uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    int_item_t  int_queue[$];
    text_char_t pending_chars[$];
    int         total_items = 0;
    int         accepted_count = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    logic       in_took = 1'b0;
    int         gap_left = 0;
    int         burst_left = 0;
    logic       next_valid;
    int_item_t  next_item;
    rx_mode_t   rx_mode = RX_STEADY;
    int         mode_left = 0;
    int         stall_left = 0;
    logic       rx_ready;

    always #10 clk = ~clk;

    // Queue one expected character at the tail.
    function automatic void append_char(input text_char_t tc);
        pending_chars = {pending_chars, tc};
    endfunction

    // Expected text of one integer: optional '-', then digits, last one marked.
    function automatic void decimal_text(input int_item_t it);
        int unsigned wbits;
        logic [63:0] wmask;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digits[$];
        text_char_t  tc;
        wbits = 8 << it.width_code;
        if (wbits > i2da_pkg::MAX_WIDTH_DEF)
            wbits = i2da_pkg::MAX_WIDTH_DEF;
        wmask = (wbits >= 64) ? '1 : ((64'd1 << wbits) - 64'd1);
        mag = it.raw_value & wmask;
        neg = 1'b0;
        if (it.width_code != i2da_pkg::WIDTH_BYTE && it.is_signed && mag[wbits-1])
        begin
            neg = 1'b1;
            mag = (~mag + 64'd1) & wmask;
        end
        do
        begin
            digits.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);
        if (neg)
        begin
            tc.out_char = i2da_pkg::CHAR_MINUS;
            tc.last_char = 1'b0;
            append_char(tc);
        end
        foreach (digits[i])
        begin
            tc.out_char = i2da_pkg::CHAR_ZERO + 8'(digits[i]);
            tc.last_char = (i == digits.size() - 1);
            append_char(tc);
        end
    endfunction

    task automatic add_item(input logic [63:0] v, input logic [1:0] code, input logic sgn,
                            input logic drain);
        int_item_t it;
        it.raw_value = v;
        it.width_code = code;
        it.is_signed = sgn;
        it.drain_first = drain;
        int_queue = {int_queue, it};
        total_items++;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] p;
        int          k;
        p = 64'd1;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 20));
            2:
            begin
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            // around a sign bit of some width
            3: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            4: return ~64'd0 >> $urandom_range(0, 63);
            default: return {$urandom, 16'h0, 16'($urandom)};
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;

        add_item(64'd0, i2da_pkg::WIDTH_BYTE, 1'b0, 1'b0);
        add_item(64'd255, i2da_pkg::WIDTH_BYTE, 1'b1, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FF80, i2da_pkg::WIDTH_BYTE, 1'b1, 1'b0);
        add_item(64'd0, WIDTH_HALF, 1'b1, 1'b0);
        add_item(64'h7FFF, WIDTH_HALF, 1'b1, 1'b0);
        add_item(64'h8000, WIDTH_HALF, 1'b1, 1'b0);
        add_item(64'hFFFF, WIDTH_HALF, 1'b0, 1'b0);
        add_item(64'hFFFF, WIDTH_HALF, 1'b1, 1'b0);
        add_item(64'hABCD_0000_0000_0009, WIDTH_HALF, 1'b1, 1'b0);
        add_item(64'd100, WIDTH_HALF, 1'b0, 1'b0);
        add_item(64'd0, WIDTH_WORD, 1'b0, 1'b0);
        add_item(64'h7FFF_FFFF, WIDTH_WORD, 1'b1, 1'b0);
        add_item(64'h8000_0000, WIDTH_WORD, 1'b1, 1'b0);
        add_item(64'hFFFF_FFFF, WIDTH_WORD, 1'b0, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFE, WIDTH_WORD, 1'b1, 1'b0);
        add_item(64'd9, WIDTH_WORD, 1'b1, 1'b0);
        add_item(64'd0, WIDTH_DWORD, 1'b1, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, WIDTH_DWORD, 1'b1, 1'b0);
        add_item(64'h8000_0000_0000_0000, WIDTH_DWORD, 1'b1, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, WIDTH_DWORD, 1'b0, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, WIDTH_DWORD, 1'b1, 1'b0);
        add_item(64'd10, WIDTH_DWORD, 1'b0, 1'b0);
        add_item(64'd10000000000000000000, WIDTH_DWORD, 1'b0, 1'b0);

        // hold the first random item and one in the middle until the text drains
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_item(random_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     i == 0 || i == RANDOM_ITEMS / 2);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_count == total_items);
        wait (pending_chars.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Sender: bursts of items separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.raw_value <= '0;
            in_ch.width_code <= i2da_pkg::WIDTH_BYTE;
            in_ch.is_signed <= 1'b0;
        end
        else if (!in_ch.valid || in_took)
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (int_queue.size() > 0 &&
                     (!int_queue[0].drain_first || pending_chars.size() == 0))
            begin
                next_item = int_queue.pop_front();
                next_valid = 1'b1;
                in_ch.raw_value <= next_item.raw_value;
                in_ch.width_code <= next_item.width_code;
                in_ch.is_signed <= next_item.is_signed;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 20);
                        default:    gap_left = $urandom_range(21, 120);
                    endcase
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // Receiver: ready pattern switches between a few stall styles.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
        end
        else
            mode_left--;
        case (rx_mode)
            RX_STEADY: rx_ready = 1'b1;
            RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
            RX_STALLS:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    rx_ready = 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 12);
                    rx_ready = 1'b0;
                end
                else
                    rx_ready = 1'b1;
            end
            default:   rx_ready = ($urandom_range(0, 7) != 0);
        endcase
        out_ch.ready <= rx_ready;
    end

    always @(posedge clk)
    begin
        text_char_t want;
        int_item_t  got_in;
        in_took <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            got_in.raw_value = in_ch.raw_value;
            got_in.width_code = in_ch.width_code;
            got_in.is_signed = in_ch.is_signed;
            got_in.drain_first = 1'b0;
            decimal_text(got_in);
            accepted_count++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("out_char: expected nothing, got %0d", out_ch.out_char);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_ch.out_char !== want.out_char)
                begin
                    $error("out_char: expected %0d, got %0d", want.out_char, out_ch.out_char);
                    error_count++;
                end
                if (out_ch.last_char !== want.last_char)
                begin
                    $error("last_char: expected %0d, got %0d", want.last_char,
                           out_ch.last_char);
                    error_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/i2da_pkg.sv
rtl/i2da_if.sv
rtl/i2da_ctrl.sv
rtl/i2da_datapath.sv
rtl/integer_to_decimal_ascii.sv
rtl/i2da_checker.sv
bench/tb.sv
